>>> sv/slot_allocator_deferred_reclaim_macros.svh
// Assertion helpers shared by the allocator modules.
`ifndef SLOT_ALLOCATOR_DEFERRED_RECLAIM_MACROS_SVH
`define SLOT_ALLOCATOR_DEFERRED_RECLAIM_MACROS_SVH

// Plain property, checked outside reset.
`define SADR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define SADR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/sadr_pkg.sv
`timescale 1ns / 1ps

package sadr_pkg;

    localparam int SLOT_COUNT_DEFAULT = 256;
    localparam int FRAME_W            = 16;
    localparam int FIF_W              = 4;
    localparam logic [FIF_W-1:0] FIF_RESET = 4'd2;

    // Register index within the configuration space
    localparam logic REG_FIF = 1'b0;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOT_LIVE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_REL,
        S_TRD,
        S_TCHK,
        S_TMOVE
    } state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  granted_slot;
        logic [8:0]  reclaimed_count;
    } res_t;

endpackage

>>> sv/sadr_ram.sv
`timescale 1ns / 1ps

module sadr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sadr_out.sv
`timescale 1ns / 1ps
`include "slot_allocator_deferred_reclaim_macros.svh"

module sadr_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sadr_pkg::res_t      res,
    output logic                busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // granted_slot[7:0], reclaimed_count[16:8], zero pad
    output logic [1:0]          m_tuser    // status[1:0]
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    sadr_pkg::res_t out_reg, out_next;
    sadr_pkg::res_t skid_reg, skid_next;
    logic           take;

    assign take = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            // Load the output if it is free or taken, else park the item in the skid stage
            if (!out_valid_reg || take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign busy     = skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.reclaimed_count, out_reg.granted_slot};
    assign m_tuser  = out_reg.status;

    `SADR_ASSERT_IMP(a_load_no_overrun, clk, rst_n, load, !skid_valid_reg, "result lost: skid full")
    `SADR_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid without output")

endmodule

>>> sv/sadr_ctrl.sv
`timescale 1ns / 1ps
`include "slot_allocator_deferred_reclaim_macros.svh"

module sadr_ctrl #(
    parameter int SLOT_COUNT = sadr_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 operation,
    input  logic [7:0]                 slot,
    input  logic [sadr_pkg::FIF_W-1:0] fif,
    input  logic                       out_busy,
    output logic                       res_load,
    output sadr_pkg::res_t             res
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int EW = SW + sadr_pkg::FRAME_W;

    sadr_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                 free_depth_reg, free_depth_next;
    logic [CW-1:0]                 fresh_reg, fresh_next;
    logic [CW-1:0]                 pend_depth_reg, pend_depth_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [sadr_pkg::FRAME_W-1:0]  frame_reg, frame_next;
    logic [SW-1:0]                 slot_reg, slot_next;
    logic [SW-1:0]                 ret_reg, ret_next;
    logic                          push_reg, push_next;
    logic [SW-1:0]                 clr_reg, clr_next;

    // Shared store: free stack from address 0 up, pending queue from the top down
    logic          mem_we, mem_re;
    logic [SW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic          live_we, live_re;
    logic [SW-1:0] live_waddr, live_raddr;
    logic          live_wdata, live_rdata;

    logic                         accept;
    logic                         slot_ok;
    logic [sadr_pkg::FRAME_W-1:0] age;

    function automatic logic [SW-1:0] pend_addr(input logic [CW-1:0] i);
        return SW'(SLOT_COUNT - 1) - SW'(i);
    endfunction

    assign in_ready = (state_reg == sadr_pkg::S_IDLE) && !out_busy;
    assign accept   = in_valid && in_ready;
    assign slot_ok  = 32'(slot) < SLOT_COUNT;
    assign age      = frame_reg - mem_rdata[EW-1:SW];

    always_comb
    begin
        state_next      = state_reg;
        free_depth_next = free_depth_reg;
        fresh_next      = fresh_reg;
        pend_depth_next = pend_depth_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        frame_next      = frame_reg;
        slot_next       = slot_reg;
        ret_next        = ret_reg;
        push_next       = push_reg;
        clr_next        = clr_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        live_we         = 1'b0;
        live_waddr      = '0;
        live_wdata      = 1'b0;
        live_re         = 1'b0;
        live_raddr      = '0;
        res_load        = 1'b0;
        res             = '0;

        unique case (state_reg)
            sadr_pkg::S_CLEAR:
            begin
                live_we    = 1'b1;
                live_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == SW'(SLOT_COUNT - 1))
                begin
                    state_next = sadr_pkg::S_IDLE;
                end
            end

            sadr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (sadr_pkg::op_t'(operation))
                        sadr_pkg::OP_ALLOC:
                        begin
                            if (free_depth_reg != '0)
                            begin
                                mem_re          = 1'b1;
                                mem_raddr       = SW'(free_depth_reg - 1'b1);
                                free_depth_next = free_depth_reg - 1'b1;
                                state_next      = sadr_pkg::S_ALLOC;
                            end
                            else if (fresh_reg != CW'(SLOT_COUNT))
                            begin
                                live_we          = 1'b1;
                                live_waddr       = SW'(fresh_reg);
                                live_wdata       = 1'b1;
                                fresh_next       = fresh_reg + 1'b1;
                                res_load         = 1'b1;
                                res.granted_slot = 8'(fresh_reg);
                            end
                            else
                            begin
                                res_load   = 1'b1;
                                res.status = sadr_pkg::STAT_FULL;
                            end
                        end
                        sadr_pkg::OP_RELEASE:
                        begin
                            if (slot_ok)
                            begin
                                live_re    = 1'b1;
                                live_raddr = SW'(slot);
                                slot_next  = SW'(slot);
                                state_next = sadr_pkg::S_REL;
                            end
                            else
                            begin
                                res_load   = 1'b1;
                                res.status = sadr_pkg::STAT_NOT_LIVE;
                            end
                        end
                        sadr_pkg::OP_TICK:
                        begin
                            frame_next = frame_reg + 1'b1;
                            idx_next   = '0;
                            cnt_next   = '0;
                            state_next = sadr_pkg::S_TRD;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end

            sadr_pkg::S_ALLOC:
            begin
                live_we          = 1'b1;
                live_waddr       = mem_rdata[SW-1:0];
                live_wdata       = 1'b1;
                res_load         = 1'b1;
                res.granted_slot = 8'(mem_rdata[SW-1:0]);
                state_next       = sadr_pkg::S_IDLE;
            end

            sadr_pkg::S_REL:
            begin
                if (live_rdata && pend_depth_reg != CW'(SLOT_COUNT))
                begin
                    live_we         = 1'b1;
                    live_waddr      = slot_reg;
                    mem_we          = 1'b1;
                    mem_waddr       = pend_addr(pend_depth_reg);
                    mem_wdata       = {frame_reg, slot_reg};
                    pend_depth_next = pend_depth_reg + 1'b1;
                end
                else
                begin
                    res.status = sadr_pkg::STAT_NOT_LIVE;
                end
                res_load   = 1'b1;
                state_next = sadr_pkg::S_IDLE;
            end

            sadr_pkg::S_TRD:
            begin
                // Push the slot returned by the last move; the queue has shrunk, so no overlap
                if (push_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = SW'(free_depth_reg);
                    mem_wdata       = EW'(ret_reg);
                    free_depth_next = free_depth_reg + 1'b1;
                    push_next       = 1'b0;
                end
                if (idx_reg < pend_depth_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pend_addr(idx_reg);
                    state_next = sadr_pkg::S_TCHK;
                end
                else
                begin
                    res_load            = 1'b1;
                    res.reclaimed_count = 9'(cnt_reg);
                    state_next          = sadr_pkg::S_IDLE;
                end
            end

            sadr_pkg::S_TCHK:
            begin
                if (age >= sadr_pkg::FRAME_W'(fif))
                begin
                    ret_next   = mem_rdata[SW-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = pend_addr(pend_depth_reg - 1'b1);
                    state_next = sadr_pkg::S_TMOVE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = sadr_pkg::S_TRD;
                end
            end

            sadr_pkg::S_TMOVE:
            begin
                // Fill the hole with the last entry and re-examine this index
                mem_we          = 1'b1;
                mem_waddr       = pend_addr(idx_reg);
                mem_wdata       = mem_rdata;
                pend_depth_next = pend_depth_reg - 1'b1;
                push_next       = 1'b1;
                state_next      = sadr_pkg::S_TRD;
            end

            default:
            begin
                state_next = sadr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sadr_pkg::S_CLEAR;
            free_depth_reg <= '0;
            fresh_reg      <= '0;
            pend_depth_reg <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            frame_reg      <= '0;
            push_reg       <= 1'b0;
            clr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_depth_reg <= free_depth_next;
            fresh_reg      <= fresh_next;
            pend_depth_reg <= pend_depth_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            frame_reg      <= frame_next;
            push_reg       <= push_next;
            clr_reg        <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        ret_reg  <= ret_next;
    end

    sadr_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sadr_ram #(
        .WIDTH (1),
        .DEPTH (SLOT_COUNT)
    ) u_live (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .re    (live_re),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    `SADR_ASSERT(a_depth_bound, clk, rst_n, 32'(free_depth_reg) + 32'(pend_depth_reg) <= SLOT_COUNT, "free and pending exceed slot count")
    `SADR_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, state_reg == sadr_pkg::S_CLEAR, !in_ready, "item taken during clearing pass")
    `SADR_ASSERT_IMP(a_store_no_rw_clash, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr, "free push overlaps pending read")

endmodule

>>> sv/slot_allocator_deferred_reclaim.sv
// Allocate: a fresh index is answered from idle; popping the free stack adds a store read.
// Release: live map read, then write back and result load.
// Tick: each pending entry is read and aged; a returned one is swapped with the last.
// One item at a time; a finished result waits in an output register with a skid stage.
// Reset: asynchronous, active low; a clearing pass then zeroes the live map.
`timescale 1ns / 1ps

module slot_allocator_deferred_reclaim #(
    parameter int SLOT_COUNT = sadr_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // slot[7:0]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // granted_slot[7:0], reclaimed_count[16:8], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [sadr_pkg::FIF_W-1:0] fif_reg, fif_next;
    logic                       cfg_wr;
    logic                       out_busy;
    logic                       res_load;
    sadr_pkg::res_t             res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        fif_next = fif_reg;
        if (cfg_wr && paddr[2] == sadr_pkg::REG_FIF)
        begin
            fif_next = pwdata[sadr_pkg::FIF_W-1:0];
        end
        prdata = '0;
        if (paddr[2] == sadr_pkg::REG_FIF)
        begin
            prdata = 32'(fif_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fif_reg <= sadr_pkg::FIF_RESET;
        end
        else
        begin
            fif_reg <= fif_next;
        end
    end

    sadr_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (s_tuser),
        .slot      (s_tdata),
        .fif       (fif_reg),
        .out_busy  (out_busy),
        .res_load  (res_load),
        .res       (res)
    );

    sadr_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import sadr_pkg::*;

    localparam int NSLOTS = SLOT_COUNT_DEFAULT;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] FIF_ADDR = 3'(REG_FIF) << 2;
    localparam int SHADOW = 0;     // pool copy that steers stimulus generation
    localparam int CHECK = 1;      // pool copy advanced on accepted items

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] slot;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'd0;    // slot[7:0]
    logic [1:0] s_tuser = 2'd0;    // operation[1:0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;          // granted_slot[7:0], reclaimed_count[16:8], zero pad
    logic [1:0] m_tuser;           // status[1:0]
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic pready;

    slot_allocator_deferred_reclaim dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Two copies of the slot pool state
    logic [7:0] free_slots [2][NSLOTS];
    int free_cnt [2];
    int fresh_next [2];
    bit live [2][NSLOTS];
    logic [7:0] pend_slot [2][NSLOTS];
    logic [15:0] pend_stamp [2][NSLOTS];
    int pend_cnt [2];
    logic [15:0] frame [2];
    logic [3:0] fif [2];

    request_t request_q [$];
    res_t predicted_replies [$];
    request_t cur_req = '0;
    bit have_item = 1'b0;
    bit item_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    bit stall_request = 1'b0;
    int hold_off_left = 0;
    int ready_mode = 0;
    int mode_left = 0;
    int mismatches = 0;

    function automatic void pool_reset(input int m);
        for (int i = 0; i < NSLOTS; i++)
        begin
            live[m][i] = 1'b0;
            free_slots[m][i] = 8'd0;
            pend_slot[m][i] = 8'd0;
            pend_stamp[m][i] = 16'd0;
        end
        free_cnt[m] = 0;
        fresh_next[m] = 0;
        pend_cnt[m] = 0;
        frame[m] = 16'd0;
        fif[m] = FIF_RESET;
    endfunction

    function automatic res_t pool_step(input int m, input request_t rq);
        res_t r;
        int g;
        int i;
        int n;
        logic [15:0] age;
        r = '0;
        r.status = STAT_OK;
        case (rq.op)
            OP_ALLOC:
            begin
                g = -1;
                if (free_cnt[m] > 0)
                begin
                    free_cnt[m]--;
                    g = free_slots[m][free_cnt[m]];
                end
                else if (fresh_next[m] < NSLOTS)
                begin
                    g = fresh_next[m];
                    fresh_next[m]++;
                end
                if (g >= 0)
                begin
                    live[m][g] = 1'b1;
                    r.granted_slot = 8'(g);
                end
                else
                    r.status = STAT_FULL;
            end
            OP_RELEASE:
            begin
                if (live[m][rq.slot] && pend_cnt[m] < NSLOTS)
                begin
                    live[m][rq.slot] = 1'b0;
                    pend_slot[m][pend_cnt[m]] = rq.slot;
                    pend_stamp[m][pend_cnt[m]] = frame[m];
                    pend_cnt[m]++;
                end
                else
                    r.status = STAT_NOT_LIVE;
            end
            OP_TICK:
            begin
                frame[m] = frame[m] + 16'd1;
                i = 0;
                n = 0;
                // swap-and-pop: the moved-in entry is checked at the same index
                while (i < pend_cnt[m])
                begin
                    age = frame[m] - pend_stamp[m][i];
                    if (age >= 16'(fif[m]))
                    begin
                        if (free_cnt[m] < NSLOTS)
                        begin
                            free_slots[m][free_cnt[m]] = pend_slot[m][i];
                            free_cnt[m]++;
                        end
                        pend_slot[m][i] = pend_slot[m][pend_cnt[m] - 1];
                        pend_stamp[m][i] = pend_stamp[m][pend_cnt[m] - 1];
                        pend_cnt[m]--;
                        n++;
                    end
                    else
                        i++;
                end
                r.reclaimed_count = 9'(n);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic plan(input logic [1:0] op, input logic [7:0] slot);
        request_t rq;
        rq.op = op;
        rq.slot = slot;
        request_q.insert(request_q.size(), rq);
        void'(pool_step(SHADOW, rq));
    endtask

    function automatic int pick_live();
        int cnt;
        int k;
        cnt = 0;
        for (int i = 0; i < NSLOTS; i++)
            if (live[SHADOW][i])
                cnt++;
        if (cnt == 0)
            return -1;
        k = $urandom_range(cnt - 1);
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (live[SHADOW][i])
            begin
                if (k == 0)
                    return i;
                k--;
            end
        end
        return -1;
    endfunction

    // Mostly well-formed traffic; the rest is stray releases and the unused code
    task automatic plan_random(input int count, input int w_alloc, input int w_rel,
                               input int w_tick);
        int p;
        int s;
        logic [7:0] noise;
        for (int j = 0; j < count; j++)
        begin
            p = $urandom_range(99);
            noise = 8'($urandom_range(255));
            if (p < w_alloc)
                plan(OP_ALLOC, noise);
            else if (p < w_alloc + w_rel)
            begin
                s = pick_live();
                plan(OP_RELEASE, (s >= 0) ? 8'(s) : noise);
            end
            else if (p < w_alloc + w_rel + w_tick)
                plan(OP_TICK, noise);
            else if (p < 97)
                plan(OP_RELEASE, noise);
            else
                plan(OP_UNUSED, noise);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || have_item || predicted_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_fif(input logic [3:0] v);
        logic [31:0] rd;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = FIF_ADDR;
        pwdata = {28'd0, v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (rd !== {28'd0, v})
            flag_mismatch("frame delay read-back", {28'd0, v}, rd);
        fif[SHADOW] = v;
        fif[CHECK] = v;
    endtask

    // Sample handshakes; check results before predicting the item taken at the same edge
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, expected none, got status %0d",
                             $time, m_tuser);
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (m_tuser !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(m_tuser));
                    if (m_tdata[7:0] !== want.granted_slot)
                        flag_mismatch("granted_slot", 32'(want.granted_slot),
                                      32'(m_tdata[7:0]));
                    if (m_tdata[16:8] !== want.reclaimed_count)
                        flag_mismatch("reclaimed_count", 32'(want.reclaimed_count),
                                      32'(m_tdata[16:8]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                predicted_replies.insert(predicted_replies.size(),
                                         pool_step(CHECK, request_t'({s_tuser, s_tdata})));
                item_taken = 1'b1;
            end
        end
    end

    // Sender: bursts of random length with random gaps between them
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken)
            begin
                have_item = 1'b0;
                item_taken = 1'b0;
            end
            if (!have_item)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_q.size() != 0)
                begin
                    cur_req = request_q.pop_front();
                    have_item = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
            s_tvalid <= have_item;
            s_tdata <= cur_req.slot;
            s_tuser <= cur_req.op;
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_tready <= 1'b0;
        end
        else if (stall_request)
        begin
            stall_request = 1'b0;
            hold_off_left = 400;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left <= 0)
            begin
                ready_mode = $urandom_range(2);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(1));
                default: m_tready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    initial
    begin
        pool_reset(SHADOW);
        pool_reset(CHECK);
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // hand-picked opening with the reset setting of two frames
        plan(OP_ALLOC, 8'hA5);
        plan(OP_ALLOC, 8'hFF);
        plan(OP_ALLOC, 8'h00);
        plan(OP_RELEASE, 8'd1);
        plan(OP_RELEASE, 8'd1);      // already pending
        plan(OP_RELEASE, 8'd200);    // never handed out
        plan(OP_RELEASE, 8'd255);
        plan(OP_UNUSED, 8'hFF);
        plan(OP_TICK, 8'h5A);        // too young to return
        plan(OP_RELEASE, 8'd0);
        plan(OP_TICK, 8'h00);
        plan(OP_RELEASE, 8'd1);      // back on the free stack
        plan(OP_ALLOC, 8'h00);
        plan(OP_TICK, 8'hFF);
        plan(OP_TICK, 8'h00);        // nothing pending
        plan(OP_ALLOC, 8'h00);
        plan(OP_RELEASE, 8'd2);
        plan(OP_RELEASE, 8'd0);
        plan(OP_RELEASE, 8'd1);
        plan(OP_TICK, 8'h00);
        plan(OP_TICK, 8'h00);
        plan(OP_ALLOC, 8'h00);
        plan(OP_ALLOC, 8'h00);
        plan(OP_ALLOC, 8'h00);
        wait_drained();

        set_fif(4'd1);
        plan_random(250, 40, 30, 22);
        wait_drained();

        // long frame delay and allocate-heavy traffic to run the pool dry
        set_fif(4'd15);
        plan_random(350, 75, 10, 7);
        wait_drained();

        set_fif(4'd0);
        plan_random(250, 35, 30, 27);
        wait_drained();

        set_fif(4'($urandom_range(3, 14)));
        stall_request = 1'b1;
        plan_random(250, 40, 30, 22);
        wait_drained();

        set_fif(FIF_RESET);
        plan_random(250, 40, 30, 22);
        wait_drained();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/sadr_pkg.sv
sv/sadr_ram.sv
sv/sadr_out.sv
sv/sadr_ctrl.sv
sv/slot_allocator_deferred_reclaim.sv
bench/tb.sv
